// ----- rtl/core/etok_pkg.sv -----
// Shared types, codes, character constants and classifiers for the expression tokenizer.
`timescale 1ns / 1ps
`default_nettype none

package etok_pkg;

  // Sizing
  localparam int POSITION_BITS_DEFAULT = 16;
  localparam int FIELD_W               = 16;
  localparam logic [FIELD_W-1:0] FIELD_MAX = 16'hFFFF;
  localparam int QUEUE_DEPTH           = 4;
  localparam int QUEUE_PTR_W           = $clog2(QUEUE_DEPTH);
  localparam int LEVEL_W               = $clog2(QUEUE_DEPTH + 1);

  // Token kinds
  localparam logic [2:0] KIND_OP  = 3'd0;
  localparam logic [2:0] KIND_ID  = 3'd1;
  localparam logic [2:0] KIND_NUM = 3'd2;
  localparam logic [2:0] KIND_HEX = 3'd3;
  localparam logic [2:0] KIND_DOT = 3'd4;
  localparam logic [2:0] KIND_END = 3'd5;

  // Scanner modes
  localparam logic [1:0] MODE_IDLE   = 2'd0;
  localparam logic [1:0] MODE_IDENT  = 2'd1;
  localparam logic [1:0] MODE_NUMBER = 2'd2;
  localparam logic [1:0] MODE_HEX    = 2'd3;

  // Characters
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_LOW_X  = 8'h78;
  localparam logic [7:0] CH_UP_X   = 8'h58;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_LOW_F  = 8'h66;
  localparam logic [7:0] CH_LOW_Z  = 8'h7A;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_F   = 8'h46;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;

  // Input beat
  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_input;
  } char_beat_t;

  // Output beat
  typedef struct packed {
    logic [2:0]         token_kind;
    logic [7:0]         operator_char;
    logic [FIELD_W-1:0] start_row;
    logic [FIELD_W-1:0] start_column;
    logic [FIELD_W-1:0] token_length;
    logic               double_dot_error;
    logic               last_of_run;
  } token_beat_t;

  // Scanner to queue: tokens produced by the current character, in order
  typedef struct packed {
    logic [1:0]  count;
    token_beat_t first;
    token_beat_t second;
    logic        halted;
  } scan_out_t;

  function automatic logic is_ws(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_NL || c == CH_CR ||
           c == CH_VT || c == CH_FF;
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= CH_LOW_A && c <= CH_LOW_Z) || (c >= CH_UP_A && c <= CH_UP_Z);
  endfunction

  function automatic logic is_dec(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic logic is_hexdig(input logic [7:0] c);
    return is_dec(c) || (c >= CH_LOW_A && c <= CH_LOW_F) || (c >= CH_UP_A && c <= CH_UP_F);
  endfunction

  function automatic logic is_op(input logic [7:0] c);
    return c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_LPAREN ||
           c == CH_RPAREN || c == CH_CARET;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/etok_scan.sv -----
// Scanner: mode and position registers plus the per-character classify/emit logic.
`timescale 1ns / 1ps
`default_nettype none

module etok_scan #(
  parameter int PositionBits = etok_pkg::POSITION_BITS_DEFAULT
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 accept,
  input  wire etok_pkg::char_beat_t beat,
  output etok_pkg::scan_out_t       result
);

  localparam int WideW = (PositionBits > etok_pkg::FIELD_W) ? PositionBits : etok_pkg::FIELD_W;

  // State
  logic [1:0]              mode, mode_next;
  logic                    halted, halted_next;
  logic [PositionBits-1:0] row, row_next;
  logic [PositionBits-1:0] col, col_next;
  logic [PositionBits-1:0] trow, trow_next;
  logic [PositionBits-1:0] tcol, tcol_next;
  logic [PositionBits-1:0] tlen, tlen_next;
  logic                    dot_seen, dot_seen_next;
  logic                    dot_repeat, dot_repeat_next;
  logic                    lone_zero, lone_zero_next;

  // Per-character working signals
  logic [7:0]            c;
  logic                  adv;
  logic                  do_idle;
  logic                  va, vb;
  etok_pkg::token_beat_t tok_a, tok_b, flush_tok;

  function automatic logic [PositionBits-1:0] sat_inc(input logic [PositionBits-1:0] v);
    return (v == {PositionBits{1'b1}}) ? v : v + 1'b1;
  endfunction

  function automatic logic [etok_pkg::FIELD_W-1:0] clamp_field(
    input logic [PositionBits-1:0] v
  );
    logic [WideW-1:0] w;
    w = WideW'(v);
    return (w > WideW'(etok_pkg::FIELD_MAX)) ? etok_pkg::FIELD_MAX
                                             : w[etok_pkg::FIELD_W-1:0];
  endfunction

  assign c = beat.char_code;

  // Token that closes the current lexeme
  always_comb begin
    flush_tok                  = '0;
    flush_tok.start_row        = clamp_field(trow);
    flush_tok.start_column     = clamp_field(tcol);
    flush_tok.token_length     = clamp_field(tlen);
    case (mode)
      etok_pkg::MODE_IDENT: flush_tok.token_kind = etok_pkg::KIND_ID;
      etok_pkg::MODE_HEX:   flush_tok.token_kind = etok_pkg::KIND_HEX;
      default: begin
        if (tlen == PositionBits'(1) && dot_seen) begin
          flush_tok.token_kind = etok_pkg::KIND_DOT;
        end else begin
          flush_tok.token_kind       = etok_pkg::KIND_NUM;
          flush_tok.double_dot_error = dot_repeat;
        end
      end
    endcase
  end

  // Next state and emitted tokens
  always_comb begin
    mode_next       = mode;
    halted_next     = halted;
    row_next        = row;
    col_next        = col;
    trow_next       = trow;
    tcol_next       = tcol;
    tlen_next       = tlen;
    dot_seen_next   = dot_seen;
    dot_repeat_next = dot_repeat;
    lone_zero_next  = lone_zero;
    adv             = 1'b0;
    do_idle         = 1'b0;
    va              = 1'b0;
    vb              = 1'b0;
    tok_a           = flush_tok;
    tok_b           = '0;
    tok_b.start_row    = clamp_field(row);
    tok_b.start_column = clamp_field(col);

    if (!halted) begin
      if (beat.end_of_input) begin
        va               = (mode != etok_pkg::MODE_IDLE);
        vb               = 1'b1;
        tok_b.token_kind = etok_pkg::KIND_END;
        mode_next        = etok_pkg::MODE_IDLE;
      end else begin
        unique case (mode)
          etok_pkg::MODE_IDENT: begin
            if (etok_pkg::is_alpha(c) || etok_pkg::is_dec(c) || c == etok_pkg::CH_UNDER) begin
              tlen_next = sat_inc(tlen);
              adv       = 1'b1;
            end else begin
              va      = 1'b1;
              do_idle = 1'b1;
            end
          end
          etok_pkg::MODE_NUMBER: begin
            if ((c == etok_pkg::CH_LOW_X || c == etok_pkg::CH_UP_X) && lone_zero &&
                tlen == PositionBits'(1)) begin
              mode_next      = etok_pkg::MODE_HEX;
              tlen_next      = PositionBits'(2);
              lone_zero_next = 1'b0;
              adv            = 1'b1;
            end else if (etok_pkg::is_dec(c) || c == etok_pkg::CH_DOT) begin
              if (c == etok_pkg::CH_DOT) begin
                dot_repeat_next = dot_repeat | dot_seen;
                dot_seen_next   = 1'b1;
              end
              lone_zero_next = 1'b0;
              tlen_next      = sat_inc(tlen);
              adv            = 1'b1;
            end else begin
              va      = 1'b1;
              do_idle = 1'b1;
            end
          end
          etok_pkg::MODE_HEX: begin
            if (etok_pkg::is_hexdig(c)) begin
              tlen_next = sat_inc(tlen);
              adv       = 1'b1;
            end else begin
              va      = 1'b1;
              do_idle = 1'b1;
            end
          end
          default: do_idle = 1'b1;
        endcase

        // Idle mode: skip whitespace, emit an operator, start a new lexeme, or halt with an end token
        if (do_idle) begin
          mode_next = etok_pkg::MODE_IDLE;
          if (etok_pkg::is_ws(c)) begin
            adv = 1'b1;
          end else if (etok_pkg::is_op(c)) begin
            vb                  = 1'b1;
            tok_b.token_kind    = etok_pkg::KIND_OP;
            tok_b.operator_char = c;
            tok_b.token_length  = etok_pkg::FIELD_W'(1);
            adv                 = 1'b1;
          end else if (etok_pkg::is_alpha(c) || etok_pkg::is_dec(c) ||
                       c == etok_pkg::CH_DOT) begin
            mode_next       = etok_pkg::is_alpha(c) ? etok_pkg::MODE_IDENT
                                                    : etok_pkg::MODE_NUMBER;
            trow_next       = row;
            tcol_next       = col;
            tlen_next       = PositionBits'(1);
            dot_seen_next   = (c == etok_pkg::CH_DOT);
            dot_repeat_next = 1'b0;
            lone_zero_next  = (c == etok_pkg::CH_ZERO);
            adv             = 1'b1;
          end else begin
            vb               = 1'b1;
            tok_b.token_kind = etok_pkg::KIND_END;
            halted_next      = 1'b1;
          end
        end

        // Position advance
        if (adv) begin
          if (c == etok_pkg::CH_NL) begin
            row_next = sat_inc(row);
            col_next = '0;
          end else begin
            col_next = sat_inc(col);
          end
        end
      end
    end
  end

  // Pack tokens in order; the last one of the run is flagged
  always_comb begin
    result                    = '0;
    result.count              = {1'b0, va} + {1'b0, vb};
    result.first              = va ? tok_a : tok_b;
    result.first.last_of_run  = !(va && vb);
    result.second             = tok_b;
    result.second.last_of_run = 1'b1;
    result.halted             = halted;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= etok_pkg::MODE_IDLE;
      halted     <= 1'b0;
      row        <= '0;
      col        <= '0;
      trow       <= '0;
      tcol       <= '0;
      tlen       <= '0;
      dot_seen   <= 1'b0;
      dot_repeat <= 1'b0;
      lone_zero  <= 1'b0;
    end else if (accept) begin
      mode       <= mode_next;
      halted     <= halted_next;
      row        <= row_next;
      col        <= col_next;
      trow       <= trow_next;
      tcol       <= tcol_next;
      tlen       <= tlen_next;
      dot_seen   <= dot_seen_next;
      dot_repeat <= dot_repeat_next;
      lone_zero  <= lone_zero_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/etok_queue.sv -----
// Result queue: takes up to two tokens per cycle, hands out one token beat per cycle on pop.
`timescale 1ns / 1ps
`default_nettype none

module etok_queue (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic [1:0]                   push_count,
  input  wire etok_pkg::token_beat_t        first,
  input  wire etok_pkg::token_beat_t        second,
  input  wire logic                         pop,
  output etok_pkg::token_beat_t             head,
  output logic [etok_pkg::LEVEL_W-1:0]      level
);

  etok_pkg::token_beat_t                entries [etok_pkg::QUEUE_DEPTH];
  logic [etok_pkg::QUEUE_PTR_W-1:0]     wptr;
  logic [etok_pkg::QUEUE_PTR_W-1:0]     rptr;
  logic [etok_pkg::QUEUE_PTR_W-1:0]     wptr_plus;

  assign wptr_plus = wptr + 1'b1;
  assign head      = entries[rptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      entries[wptr] <= first;
    end
    if (push_count == 2'd2) begin
      entries[wptr_plus] <= second;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      level <= '0;
    end else begin
      wptr  <= wptr + etok_pkg::QUEUE_PTR_W'(push_count);
      rptr  <= rptr + etok_pkg::QUEUE_PTR_W'(pop);
      level <= level + etok_pkg::LEVEL_W'(push_count) - etok_pkg::LEVEL_W'(pop);
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/expression_tokenizer.sv -----
// Top level of the streaming expression tokenizer: scanner plus result queue.
//
//   Channel | Direction | Handshake             | Payload
//   --------+-----------+-----------------------+-------------------------------
//   src     | in        | src_valid / src_ready | char_beat_t (char, end mark)
//   tok     | out       | tok_valid / tok_ready | token_beat_t (one token)
//
// One character beat is taken per cycle while src_ready is high; its tokens (zero,
// one or two) enter the four-entry result queue at that same edge and are handed
// out on tok in order from the queue head. src_ready is high while the queue has
// room for two tokens, so a stream that makes at most one token per character runs
// at one beat per cycle while tok_ready stays high. A character that closes a lexeme
// and starts an operator or end token pushes two tokens. Synchronous reset clears
// scanner state and the queue and holds src_ready low.
`timescale 1ns / 1ps
`default_nettype none

module expression_tokenizer #(
  parameter int PositionBits = etok_pkg::POSITION_BITS_DEFAULT
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  src_valid,
  output logic                       src_ready,
  input  wire etok_pkg::char_beat_t  src_beat,
  output logic                       tok_valid,
  input  wire logic                  tok_ready,
  output etok_pkg::token_beat_t      tok_beat
);

  logic                            accept;
  logic                            pop;
  logic [1:0]                      push_count;
  logic [etok_pkg::LEVEL_W-1:0]    level;
  etok_pkg::scan_out_t             scan_res;

  // Handshakes
  assign src_ready  = !rst && (level <= etok_pkg::LEVEL_W'(etok_pkg::QUEUE_DEPTH - 2));
  assign accept     = src_valid && src_ready;
  assign tok_valid  = (level != '0);
  assign pop        = tok_valid && tok_ready;
  assign push_count = accept ? scan_res.count : 2'd0;

  etok_scan #(
    .PositionBits(PositionBits)
  ) u_scan (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .beat   (src_beat),
    .result (scan_res)
  );

  etok_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_count (push_count),
    .first      (scan_res.first),
    .second     (scan_res.second),
    .pop        (pop),
    .head       (tok_beat),
    .level      (level)
  );

  // A halted scanner produces nothing
  assert property (@(posedge clk) disable iff (rst)
    (accept && scan_res.halted) |-> (scan_res.count == 2'd0))
    else $error("halted scanner emitted a token");

  // An accepted beat always finds room for two tokens
  assert property (@(posedge clk) disable iff (rst)
    accept |-> (etok_pkg::LEVEL_W'(2) + level <= etok_pkg::LEVEL_W'(etok_pkg::QUEUE_DEPTH)))
    else $error("queue overflow on accept");

  // Fill level follows pushes and pops
  assert property (@(posedge clk) disable iff (rst)
    !rst |=> (level == $past(level) + etok_pkg::LEVEL_W'($past(push_count))
                       - etok_pkg::LEVEL_W'($past(pop))))
    else $error("queue level out of step");

  // A single-token run is always flagged as its own last token
  assert property (@(posedge clk) disable iff (rst)
    (accept && scan_res.count == 2'd1) |-> scan_res.first.last_of_run)
    else $error("lone token not marked last of run");

endmodule

`default_nettype wire
